>>> sv/tlvf_pkg.sv
// shared types and constants of the tlv record tag filter
// no dependencies; used by every module of the block
`default_nettype none

package tlvf_pkg;

    localparam logic [1:0] MODE_HEADER = 2'd0;
    localparam logic [1:0] MODE_COPY   = 2'd1;
    localparam logic [1:0] MODE_SKIP   = 2'd2;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [2:0] ADDR_TARGET_TAG = 3'd0;

    // results caused by one input byte, one to four of them
    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            bare;
        logic            stream_end;
        logic            found;
        logic [15:0]     offset;
    } t_group;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        byte_valid;
        logic        stream_end;
        logic        tag_found;
        logic [15:0] found_offset;
    } t_result;

endpackage

`default_nettype wire

>>> sv/tlvf_front.sv
// front part: takes stream bytes, tracks record headers and builds result groups
// depends on tlvf_pkg
`default_nettype none

module tlvf_front #(
    parameter int unsigned MAX_STREAM_BYTES = 65520
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire  [15:0]          i_target_tag,
    input  wire                  i_in_valid,
    input  wire  [7:0]           i_in_byte,
    input  wire                  i_in_last,
    output logic                 o_in_ready,
    input  wire                  i_queue_full,
    output logic                 o_push,
    output tlvf_pkg::t_group     o_group
);

    localparam logic [15:0] MaxBytes = 16'(MAX_STREAM_BYTES);

    logic [1:0]       r_hc, n_hc;
    logic [7:0]       r_hb [3];
    logic [7:0]       n_hb [3];
    logic [15:0]      r_left, n_left;
    logic [1:0]       r_mode, n_mode;
    logic [15:0]      r_pos, n_pos;
    logic             r_fm_seen, n_fm_seen;
    logic [15:0]      r_fm_off, n_fm_off;

    logic             take;
    logic [2:0]       cnt;
    logic [15:0]      tag;
    logic [15:0]      size;
    logic [15:0]      left_dec;
    logic             accept;

    assign o_in_ready = !i_queue_full;
    assign accept     = i_in_valid && o_in_ready;
    assign take       = r_pos < MaxBytes;
    assign tag        = {r_hb[1], r_hb[0]};
    assign size       = {i_in_byte, r_hb[2]};
    assign left_dec   = r_left - 16'd1;

    always_comb begin
        n_hc      = r_hc;
        n_hb      = r_hb;
        n_left    = r_left;
        n_mode    = r_mode;
        n_pos     = r_pos;
        n_fm_seen = r_fm_seen;
        n_fm_off  = r_fm_off;
        cnt       = 3'd0;
        o_group   = '0;

        if (take) begin
            n_pos = r_pos + 16'd1;
            case (r_mode)
                tlvf_pkg::MODE_COPY: begin
                    o_group.bytes[0] = i_in_byte;
                    cnt              = 3'd1;
                    n_left           = left_dec;
                    if (left_dec == 16'd0) begin
                        n_mode = tlvf_pkg::MODE_HEADER;
                    end
                end
                tlvf_pkg::MODE_SKIP: begin
                    n_left = left_dec;
                    if (left_dec == 16'd0) begin
                        n_mode = tlvf_pkg::MODE_HEADER;
                    end
                end
                default: begin
                    n_mode = tlvf_pkg::MODE_HEADER;
                    if (r_hc != 2'd3) begin
                        n_hb[r_hc] = i_in_byte;
                        n_hc       = r_hc + 2'd1;
                    end else begin
                        n_hc = 2'd0;
                        if (tag == i_target_tag) begin
                            if (!r_fm_seen) begin
                                n_fm_seen = 1'b1;
                                n_fm_off  = r_pos - 16'd3;
                            end
                            if (size != 16'd0) begin
                                n_mode = tlvf_pkg::MODE_SKIP;
                                n_left = size;
                            end
                        end else begin
                            o_group.bytes = {i_in_byte, r_hb[2], r_hb[1], r_hb[0]};
                            cnt           = 3'd4;
                            if (size != 16'd0) begin
                                n_mode = tlvf_pkg::MODE_COPY;
                                n_left = size;
                            end
                        end
                    end
                end
            endcase
        end

        if (i_in_last) begin
            // header fragment left at stream end goes out as it stands
            if (n_mode != tlvf_pkg::MODE_COPY && n_mode != tlvf_pkg::MODE_SKIP
                && n_hc != 2'd0) begin
                o_group.bytes = {8'd0, n_hb[2], n_hb[1], n_hb[0]};
                cnt           = {1'b0, n_hc};
            end
            if (cnt == 3'd0) begin
                o_group.bare = 1'b1;
                cnt          = 3'd1;
            end
            o_group.stream_end = 1'b1;
            o_group.found      = n_fm_seen;
            o_group.offset     = n_fm_seen ? n_fm_off : 16'd0;
        end

        o_group.last_idx = 2'(cnt - 3'd1);
    end

    assign o_push = accept && (cnt != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hc      <= 2'd0;
            r_left    <= 16'd0;
            r_mode    <= tlvf_pkg::MODE_HEADER;
            r_pos     <= 16'd0;
            r_fm_seen <= 1'b0;
            r_fm_off  <= 16'd0;
        end else if (accept) begin
            if (i_in_last) begin
                r_hc      <= 2'd0;
                r_left    <= 16'd0;
                r_mode    <= tlvf_pkg::MODE_HEADER;
                r_pos     <= 16'd0;
                r_fm_seen <= 1'b0;
                r_fm_off  <= 16'd0;
            end else begin
                r_hc      <= n_hc;
                r_left    <= n_left;
                r_mode    <= n_mode;
                r_pos     <= n_pos;
                r_fm_seen <= n_fm_seen;
                r_fm_off  <= n_fm_off;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_hb <= n_hb;
        end
    end

endmodule

`default_nettype wire

>>> sv/tlvf_queue.sv
// short queue of result groups between the front and back parts
// depends on tlvf_pkg
`default_nettype none

module tlvf_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  tlvf_pkg::t_group     i_group,
    output logic                 o_full,
    input  wire                  i_pop,
    output tlvf_pkg::t_group     o_head,
    output logic                 o_empty
);

    localparam int unsigned AW = tlvf_pkg::QUEUE_AW;

    tlvf_pkg::t_group r_mem [tlvf_pkg::QUEUE_DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [AW:0]      r_count;

    assign o_full  = r_count == (AW+1)'(tlvf_pkg::QUEUE_DEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_group;
        end
    end

endmodule

`default_nettype wire

>>> sv/tlvf_back.sv
// back part: splits queued groups into single results behind an output register
// depends on tlvf_pkg
`default_nettype none

module tlvf_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  tlvf_pkg::t_group     i_head,
    input  wire                  i_empty,
    output logic                 o_pop,
    output logic                 o_out_valid,
    input  wire                  i_out_ready,
    output tlvf_pkg::t_result    o_result
);

    logic [1:0]          r_sel;
    logic                r_valid;
    tlvf_pkg::t_result   r_res, n_res;
    logic                load;
    logic                final_one;

    assign load      = !i_empty && (!r_valid || i_out_ready);
    assign final_one = r_sel == i_head.last_idx;
    assign o_pop     = load && final_one;

    always_comb begin
        n_res              = '0;
        n_res.out_byte     = i_head.bare ? 8'd0 : i_head.bytes[r_sel];
        n_res.byte_valid   = !i_head.bare;
        if (final_one && i_head.stream_end) begin
            n_res.stream_end   = 1'b1;
            n_res.tag_found    = i_head.found;
            n_res.found_offset = i_head.offset;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_sel   <= final_one ? 2'd0 : r_sel + 2'd1;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid = r_valid;
    assign o_result    = r_res;

endmodule

`default_nettype wire

>>> sv/tlv_record_tag_filter.sv
// top level of the tlv record tag filter: config register, front, queue, back
// depends on tlvf_pkg, tlvf_front, tlvf_queue, tlvf_back
//
//   channel  | signals                                        | transfer when
//   ---------+------------------------------------------------+-------------------------
//   input    | i_in_byte, i_in_last                           | i_in_valid & o_in_ready
//   output   | o_out_byte, o_byte_valid, o_stream_end,        | o_out_valid & i_out_ready
//            | o_tag_found, o_found_offset                    |
//   config   | psel, penable, pwrite, paddr, pwdata, prdata   | psel & penable & pready
//
// one input byte per cycle while the four-entry group queue has room
// a kept header gives four results, drained one a cycle by the output register while i_out_ready is high
// results of an accepted byte pass through a group queue entry and then the output register
// reset is synchronous and clears control state only; target tag resets to zero
`default_nettype none

module tlv_record_tag_filter #(
    parameter int unsigned MAX_STREAM_BYTES = 65520
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_in_valid,
    output logic        o_in_ready,
    input  wire  [7:0]  i_in_byte,
    input  wire         i_in_last,
    output logic        o_out_valid,
    input  wire         i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_byte_valid,
    output logic        o_stream_end,
    output logic        o_tag_found,
    output logic [15:0] o_found_offset,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [15:0]        r_target_tag;
    logic               queue_full;
    logic               queue_empty;
    logic               push;
    logic               pop;
    tlvf_pkg::t_group   group_in;
    tlvf_pkg::t_group   group_head;
    tlvf_pkg::t_result  result;

    assign pready = 1'b1;
    assign prdata = (paddr == tlvf_pkg::ADDR_TARGET_TAG) ? {16'd0, r_target_tag} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_tag <= 16'd0;
        end else if (psel && penable && pwrite && pready
                     && paddr == tlvf_pkg::ADDR_TARGET_TAG) begin
            r_target_tag <= pwdata[15:0];
        end
    end

    tlvf_front #(
        .MAX_STREAM_BYTES(MAX_STREAM_BYTES)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_target_tag (r_target_tag),
        .i_in_valid   (i_in_valid),
        .i_in_byte    (i_in_byte),
        .i_in_last    (i_in_last),
        .o_in_ready   (o_in_ready),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_group      (group_in)
    );

    tlvf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_group (group_in),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_head  (group_head),
        .o_empty (queue_empty)
    );

    tlvf_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (group_head),
        .i_empty     (queue_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result)
    );

    assign o_out_byte     = result.out_byte;
    assign o_byte_valid   = result.byte_valid;
    assign o_stream_end   = result.stream_end;
    assign o_tag_found    = result.tag_found;
    assign o_found_offset = result.found_offset;

endmodule

`default_nettype wire
